### src/lsm_pkg.sv
package lsm_pkg;

  // Frame geometry limits.
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // Field and register widths.
  localparam int SIZE_W    = 11;
  localparam int PIX_W     = 16;
  localparam int LUMA_W    = 8;
  localparam int LAP_W     = 10;
  localparam int SHARP_W   = 10;
  localparam int CFG_IDX_W = 2;

  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int ADDR_W   = COL_W + 1;
  localparam int LINE_DEPTH = 1 << ADDR_W;
  localparam int CNT_W    = $clog2((MAX_WIDTH - 2) * (MAX_HEIGHT - 2) + 1);
  localparam int SUM_W    = CNT_W + LAP_W;
  localparam int DIV_STEP_W = $clog2(SHARP_W);

  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  // Register reset values.
  localparam logic [SIZE_W-1:0] FRAME_WIDTH_RST  = SIZE_W'(320);
  localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RST = SIZE_W'(240);

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  // Luma weights, in units of 1/256.
  localparam logic [7:0] COEF_R = 8'd77;
  localparam logic [7:0] COEF_G = 8'd150;
  localparam logic [7:0] COEF_B = 8'd29;

  // One classified pixel on its way from the front to the back.
  typedef struct packed {
    logic [LUMA_W-1:0] luma;
    logic [COL_W-1:0]  col;
    logic              row_odd;
    logic              first;
    logic              interior;
    logic              last;
  } lsm_item_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] cnt;
  } lsm_div_req_t;

  typedef struct packed {
    logic               valid;
    logic [SHARP_W-1:0] quot;
  } lsm_div_rsp_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } lsm_div_state_t;

endpackage

### src/lsm_front.sv
module lsm_front
  import lsm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PIX_W-1:0]     in_pixel_rgb565,
  input  logic                 q_full,
  output logic                 q_push,
  output lsm_item_t            q_item,
  output logic                 restart
);

  logic [SIZE_W-1:0] fw_r, fh_r;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [SIZE_W-1:0] w_eff, h_eff;
  logic              col_last, row_last, interior;
  logic [4:0]        r5, b5;
  logic [5:0]        g6;
  logic [7:0]        r8, g8, b8;
  logic [15:0]       luma_acc;

  // Register writes; a write to a known register restarts the frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= FRAME_WIDTH_RST;
      fh_r <= FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  fw_r <= cfg_wdata;
        REG_FRAME_HEIGHT: fh_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    restart = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  restart = 1'b1;
        REG_FRAME_HEIGHT: restart = 1'b1;
        default:          restart = 1'b0;
      endcase
    end
  end

  // Sizes outside the supported range are clamped.
  assign w_eff = (fw_r == '0) ? SIZE_W'(1) :
                 (fw_r > SIZE_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) : fw_r;
  assign h_eff = (fh_r == '0) ? SIZE_W'(1) :
                 (fh_r > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : fh_r;

  assign col_last = (SIZE_W'(col_r) == w_eff - SIZE_W'(1));
  assign row_last = (SIZE_W'(row_r) == h_eff - SIZE_W'(1));
  assign interior = (w_eff >= SIZE_W'(3)) && (row_r >= ROW_W'(2)) &&
                    (col_r != '0) && (SIZE_W'(col_r) + SIZE_W'(2) <= w_eff);

  // RGB565 to 8-bit channels by bit replication, then weighted luma.
  assign r5 = in_pixel_rgb565[15:11];
  assign g6 = in_pixel_rgb565[10:5];
  assign b5 = in_pixel_rgb565[4:0];
  assign r8 = {r5, r5[4:2]};
  assign g8 = {g6, g6[5:4]};
  assign b8 = {b5, b5[4:2]};
  assign luma_acc = 16'(r8) * 16'(COEF_R) + 16'(g8) * 16'(COEF_G) +
                    16'(b8) * 16'(COEF_B);

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.luma     = luma_acc[15:8];
    q_item.col      = col_r;
    q_item.row_odd  = row_r[0];
    q_item.first    = (col_r == '0);
    q_item.interior = interior;
    q_item.last     = col_last && row_last;
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (q_push) begin
      if (col_last) begin
        col_nxt = '0;
        row_nxt = row_last ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

### src/lsm_queue.sv
module lsm_queue
  import lsm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  lsm_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      valid,
  output lsm_item_t pop_item
);

  lsm_item_t          slot_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  cnt_r;

  assign full     = (cnt_r == QCNT_W'(QDEPTH));
  assign valid    = (cnt_r != '0);
  assign pop_item = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

endmodule

### src/lsm_div.sv
module lsm_div
  import lsm_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  lsm_div_req_t req,
  input  logic         take,
  output lsm_div_rsp_t rsp
);

  lsm_div_state_t          state_r, state_nxt;
  logic [SUM_W-1:0]        rem_r, rem_nxt;
  logic [SUM_W-1:0]        dsh_r, dsh_nxt;
  logic [SHARP_W-1:0]      q_r, q_nxt;
  logic [DIV_STEP_W-1:0]   step_r, step_nxt;
  logic                    ge;

  // Restoring division, one quotient bit per cycle, most significant first.
  // The mean never exceeds the largest Laplacian, so SHARP_W bits suffice.
  assign ge = (rem_r >= dsh_r);

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    dsh_nxt   = dsh_r;
    q_nxt     = q_r;
    step_nxt  = step_r;
    case (state_r)
      DIV_IDLE: begin
        if (req.start) begin
          rem_nxt  = req.sum;
          dsh_nxt  = SUM_W'(req.cnt) << (SHARP_W - 1);
          q_nxt    = '0;
          step_nxt = DIV_STEP_W'(SHARP_W - 1);
          state_nxt = (req.cnt == '0) ? DIV_DONE : DIV_RUN;
        end
      end
      DIV_RUN: begin
        rem_nxt  = ge ? rem_r - dsh_r : rem_r;
        q_nxt    = {q_r[SHARP_W-2:0], ge};
        dsh_nxt  = dsh_r >> 1;
        step_nxt = step_r - DIV_STEP_W'(1);
        if (step_r == '0) begin
          state_nxt = DIV_DONE;
        end
      end
      DIV_DONE: begin
        if (take) begin
          state_nxt = DIV_IDLE;
        end
      end
      default: state_nxt = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DIV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    dsh_r  <= dsh_nxt;
    q_r    <= q_nxt;
    step_r <= step_nxt;
  end

  assign rsp.valid = (state_r == DIV_DONE);
  assign rsp.quot  = q_r;

endmodule

### src/lsm_back.sv
module lsm_back
  import lsm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               restart,
  input  logic               q_valid,
  input  lsm_item_t          q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SHARP_W-1:0] out_sharpness
);

  logic [LUMA_W-1:0] line_mem [LINE_DEPTH];
  logic [ADDR_W-1:0] addr_a, addr_b, addr_w;
  logic [LUMA_W-1:0] rd_a_r, rd_b_r;

  logic              s1_valid_r;
  lsm_item_t         s1_item_r;
  logic [LUMA_W-1:0] win_l_r, win_c_r;
  logic [LAP_W-1:0]  pos, neg, lap;

  logic              s2_valid_r, s2_int_r, s2_last_r;
  logic [LAP_W-1:0]  s2_lap_r;

  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              fin_busy_r;
  logic              take;
  lsm_div_req_t      div_req;
  lsm_div_rsp_t      div_rsp;
  logic              out_valid_r;
  logic [SHARP_W-1:0] out_sharp_r;

  // New pixels wait from the last pixel of a frame until its result is taken.
  assign q_pop = q_valid && !fin_busy_r;

  // Port A fetches the upper row one column ahead. Port B fetches the pixel
  // two rows up, which the current pixel overwrites in the same cycle; in the
  // first column no Laplacian is due, so it fetches upper-row column 0.
  assign addr_a = {~q_item.row_odd, q_item.col + COL_W'(1)};
  assign addr_b = q_item.first ? {~q_item.row_odd, COL_W'(0)} :
                                 {q_item.row_odd, q_item.col};
  assign addr_w = {q_item.row_odd, q_item.col};

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_a_r <= line_mem[addr_a];
      rd_b_r <= line_mem[addr_b];
      line_mem[addr_w] <= q_item.luma;
      s1_item_r <= q_item;
    end
  end

  // Stage 2: 3-wide window over the upper row and the absolute Laplacian.
  assign pos = {win_c_r, 2'b00};
  assign neg = LAP_W'(win_l_r) + LAP_W'(rd_a_r) + LAP_W'(rd_b_r) +
               LAP_W'(s1_item_r.luma);
  assign lap = (pos >= neg) ? pos - neg : neg - pos;

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      if (s1_item_r.first) begin
        win_l_r <= rd_b_r;
      end else begin
        win_l_r <= win_c_r;
      end
      win_c_r  <= rd_a_r;
      s2_lap_r <= lap;
      s2_int_r <= s1_item_r.interior;
      s2_last_r <= s1_item_r.last;
    end
  end

  // Stage 3: accumulate, hand the frame total to the divider at frame end.
  assign sum_nxt = (s2_valid_r && s2_int_r) ? sum_r + SUM_W'(s2_lap_r) : sum_r;
  assign cnt_nxt = (s2_valid_r && s2_int_r) ? cnt_r + CNT_W'(1) : cnt_r;

  assign div_req.start = s2_valid_r && s2_last_r;
  assign div_req.sum   = sum_nxt;
  assign div_req.cnt   = cnt_nxt;

  lsm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .take  (take),
    .rsp   (div_rsp)
  );

  assign take = div_rsp.valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      sum_r       <= '0;
      cnt_r       <= '0;
      fin_busy_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= q_pop;
      s2_valid_r <= s1_valid_r;
      if (restart || div_req.start) begin
        sum_r <= '0;
        cnt_r <= '0;
      end else begin
        sum_r <= sum_nxt;
        cnt_r <= cnt_nxt;
      end
      if (q_pop && q_item.last) begin
        fin_busy_r <= 1'b1;
      end else if (take) begin
        fin_busy_r <= 1'b0;
      end
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_sharp_r <= div_rsp.quot;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_sharpness = out_sharp_r;

endmodule

### src/laplacian_sharpness_meter_top.sv
// Channel   Direction  Handshake                Payload
// in        input      in_valid / in_ready      in_pixel_rgb565 (16 bits, RGB565)
// out       output     out_valid / out_ready    out_sharpness (10 bits)
// cfg       input      cfg_we (no wait)         cfg_index (2 bits), cfg_wdata (11 bits)
//
// One pixel request is accepted per clock while the four-entry queue has room.
// The back end drains the queue at one pixel per clock except while a frame
// result is pending. After the last pixel of a frame it stops draining while
// the frame total passes the pipeline registers, the divider forms the mean
// bit by bit, and the mean moves into the output register.
// Reset (synchronous, active low) restores the default frame size and empties
// the queue, pipeline and accumulator; the line store is not cleared.
// A result waiting in the output register does not block input until the next
// frame's mean is ready; draining then waits for it to be read, and the queue fills.
module laplacian_sharpness_meter_top
  import lsm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PIX_W-1:0]     in_pixel_rgb565,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SHARP_W-1:0]   out_sharpness
);

  // The front end holds the frame size registers, tracks the raster position,
  // converts each pixel to luma and marks whether it closes a Laplacian of
  // an interior pixel, starts a row, or ends the frame.
  logic      q_full;
  logic      q_push;
  lsm_item_t q_push_item;
  logic      restart;

  // The queue decouples the front from the back, so up to four incoming
  // pixels are still taken while the back end finishes a frame result.
  logic      q_valid;
  logic      q_pop;
  lsm_item_t q_pop_item;

  lsm_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pixel_rgb565 (in_pixel_rgb565),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_item          (q_push_item),
    .restart         (restart)
  );

  lsm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_item  (q_pop_item)
  );

  // The back end keeps two rows of luma in a line store, forms the absolute
  // 4-neighbour Laplacian of the pixel one row up, accumulates it, and at
  // frame end divides the sum by the interior count.
  lsm_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .restart       (restart),
    .q_valid       (q_valid),
    .q_item        (q_pop_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sharpness (out_sharpness)
  );

endmodule
